### src/skvdm_pkg.sv
// ---------------------------------------------------------------------------
// skvdm_pkg: shared types for the sorted key/value delta merge unit
// Operation and status codes, datapath command set and status bundle.
// ---------------------------------------------------------------------------
package skvdm_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_BUILD  = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_RANGE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DELTA_FULL = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [63:0] NOT_FOUND = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          CNT_W     = 11;

	// datapath commands
	typedef enum logic [4:0] {
		C_NONE,
		C_LOAD,
		C_INS,
		C_BLD_OVF,
		C_SRCH_INIT,
		C_SRCH_RD,
		C_SRCH_STEP,
		C_LK_RD,
		C_LK_FIN,
		C_RG_INIT,
		C_RG_RD,
		C_RG_ACC,
		C_SORT_INIT,
		C_SORT_RDI,
		C_SORT_KEY,
		C_SORT_RDJ,
		C_SORT_CMP,
		C_SORT_PLACE,
		C_MRG_INIT,
		C_MRG_RD,
		C_MRG_WR,
		C_SEP_INIT,
		C_SEP_RD,
		C_SEP_WR,
		C_FIN
	} cmd_t;

	// datapath status toward the controller
	typedef struct packed {
		logic [1:0] op;
		logic       delta_empty;
		logic       overflow;
		logic       range_empty;
		logic       srch_done;
		logic       sort_done;
		logic       sort_less;
		logic       j_one;
		logic       mrg_done;
		logic       sep_done;
		logic       rg_ok;
		logic       out_free;
	} dp_stat_t;

endpackage

### src/sorted_kv_store_delta_merge_unit.sv
// ---------------------------------------------------------------------------
// sorted_kv_store_delta_merge_unit: sorted key/value store with delta buffer
// Insert, build (sort delta, merge, write separators), point lookup and range sum.
// ---------------------------------------------------------------------------
// Insert: load, write to the delta buffer, then register the result.
// Lookup: binary search over the store entries, then a read and compare.
// Range sum: search, then a read and accumulate per matching entry (one store
// read port); an empty range goes to the result. Build: sort delta, merge,
// then leaf separators; empty or overflowing build: to result. One word at a time.
// Reset clears entry and delta counts and output valid; no memory clearing pass.
module sorted_kv_store_delta_merge_unit
	import skvdm_pkg::*;
#(
	parameter int STORE_DEPTH = 1024,
	parameter int DELTA_DEPTH = 64,
	parameter int LEAF_SPAN   = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // key_or_low, pair_value, range_high
	input  logic [1:0]   s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [335:0] m_tdata,  // found_value, match_count, key_total,
	                               // value_total, first_key, last_key, zero pad
	output logic [2:0]   m_tuser   // status, found
);

	cmd_t     cmd;
	dp_stat_t stat;

	logic [1:0]       o_status;
	logic             o_found;
	logic [63:0]      o_fval, o_ksum, o_vsum, o_fkey, o_lkey;
	logic [CNT_W-1:0] o_cnt;

	skvdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	skvdm_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.DELTA_DEPTH (DELTA_DEPTH),
		.LEAF_SPAN   (LEAF_SPAN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_tuser),
		.in_key     (s_tdata[63:0]),
		.in_value   (s_tdata[127:64]),
		.in_high    (s_tdata[191:128]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (o_status),
		.out_found  (o_found),
		.out_fval   (o_fval),
		.out_cnt    (o_cnt),
		.out_ksum   (o_ksum),
		.out_vsum   (o_vsum),
		.out_fkey   (o_fkey),
		.out_lkey   (o_lkey)
	);

	// result packing
	assign m_tuser = {o_found, o_status};
	assign m_tdata = {5'b0, o_lkey, o_fkey, o_vsum, o_ksum, o_cnt, o_fval};

endmodule

### src/skvdm_ctrl.sv
// ---------------------------------------------------------------------------
// skvdm_ctrl: sequencer for the delta merge unit
// One-hot state machine that steps the datapath through each operation.
// ---------------------------------------------------------------------------
module skvdm_ctrl
	import skvdm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output cmd_t     cmd
);

	typedef enum logic [16:0] {
		S_IDLE       = 17'h00001,
		S_DISPATCH   = 17'h00002,
		S_SRCH       = 17'h00004,
		S_SRCH_STEP  = 17'h00008,
		S_LK_FIN     = 17'h00010,
		S_RG_RD      = 17'h00020,
		S_RG_ACC     = 17'h00040,
		S_SORT_TEST  = 17'h00080,
		S_SORT_KEY   = 17'h00100,
		S_SORT_RDJ   = 17'h00200,
		S_SORT_CMP   = 17'h00400,
		S_SORT_PLACE = 17'h00800,
		S_MRG_RD     = 17'h01000,
		S_MRG_WR     = 17'h02000,
		S_SEP_RD     = 17'h04000,
		S_SEP_WR     = 17'h08000,
		S_FIN        = 17'h10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd     = C_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = C_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.op)
					OP_INSERT: begin
						cmd     = C_INS;
						state_d = S_FIN;
					end
					OP_BUILD: begin
						if (stat.delta_empty) begin
							state_d = S_FIN;
						end else if (stat.overflow) begin
							cmd     = C_BLD_OVF;
							state_d = S_FIN;
						end else begin
							cmd     = C_SORT_INIT;
							state_d = S_SORT_TEST;
						end
					end
					OP_LOOKUP: begin
						cmd     = C_SRCH_INIT;
						state_d = S_SRCH;
					end
					default: begin
						if (stat.range_empty) begin
							state_d = S_FIN;
						end else begin
							cmd     = C_SRCH_INIT;
							state_d = S_SRCH;
						end
					end
				endcase
			end
			S_SRCH: begin
				if (!stat.srch_done) begin
					cmd     = C_SRCH_RD;
					state_d = S_SRCH_STEP;
				end else if (stat.op == OP_LOOKUP) begin
					cmd     = C_LK_RD;
					state_d = S_LK_FIN;
				end else begin
					cmd     = C_RG_INIT;
					state_d = S_RG_RD;
				end
			end
			S_SRCH_STEP: begin
				cmd     = C_SRCH_STEP;
				state_d = S_SRCH;
			end
			S_LK_FIN: begin
				cmd     = C_LK_FIN;
				state_d = S_FIN;
			end
			S_RG_RD: begin
				cmd     = C_RG_RD;
				state_d = S_RG_ACC;
			end
			S_RG_ACC: begin
				cmd     = C_RG_ACC;
				state_d = stat.rg_ok ? S_RG_RD : S_FIN;
			end
			S_SORT_TEST: begin
				if (stat.sort_done) begin
					cmd     = C_MRG_INIT;
					state_d = S_MRG_RD;
				end else begin
					cmd     = C_SORT_RDI;
					state_d = S_SORT_KEY;
				end
			end
			S_SORT_KEY: begin
				cmd     = C_SORT_KEY;
				state_d = S_SORT_RDJ;
			end
			S_SORT_RDJ: begin
				cmd     = C_SORT_RDJ;
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				cmd = C_SORT_CMP;
				if (!stat.sort_less)
					state_d = S_SORT_TEST;
				else if (stat.j_one)
					state_d = S_SORT_PLACE;
				else
					state_d = S_SORT_RDJ;
			end
			S_SORT_PLACE: begin
				cmd     = C_SORT_PLACE;
				state_d = S_SORT_TEST;
			end
			S_MRG_RD: begin
				if (stat.mrg_done) begin
					cmd     = C_SEP_INIT;
					state_d = S_SEP_RD;
				end else begin
					cmd     = C_MRG_RD;
					state_d = S_MRG_WR;
				end
			end
			S_MRG_WR: begin
				cmd     = C_MRG_WR;
				state_d = S_MRG_RD;
			end
			S_SEP_RD: begin
				if (stat.sep_done) begin
					state_d = S_FIN;
				end else begin
					cmd     = C_SEP_RD;
					state_d = S_SEP_WR;
				end
			end
			S_SEP_WR: begin
				cmd     = C_SEP_WR;
				state_d = S_SEP_RD;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd     = C_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### src/skvdm_dp.sv
// ---------------------------------------------------------------------------
// skvdm_dp: datapath of the delta merge unit
// Store, delta and separator memories, search/walk/sort/merge registers,
// accumulators and the output register.
// ---------------------------------------------------------------------------
module skvdm_dp
	import skvdm_pkg::*;
#(
	parameter int STORE_DEPTH = 1024,
	parameter int DELTA_DEPTH = 64,
	parameter int LEAF_SPAN   = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output dp_stat_t      stat,
	input  logic [1:0]    in_op,
	input  logic [63:0]   in_key,
	input  logic [63:0]   in_value,
	input  logic [63:0]   in_high,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    out_status,
	output logic          out_found,
	output logic [63:0]   out_fval,
	output logic [CNT_W-1:0] out_cnt,
	output logic [63:0]   out_ksum,
	output logic [63:0]   out_vsum,
	output logic [63:0]   out_fkey,
	output logic [63:0]   out_lkey
);

	localparam int AW       = $clog2(STORE_DEPTH);
	localparam int CW       = $clog2(STORE_DEPTH + 1);
	localparam int DAW      = (DELTA_DEPTH > 1) ? $clog2(DELTA_DEPTH) : 1;
	localparam int DCW      = $clog2(DELTA_DEPTH + 1);
	localparam int SEP_DEPTH = (STORE_DEPTH + LEAF_SPAN - 1) / LEAF_SPAN;
	localparam int SPW      = (SEP_DEPTH > 1) ? $clog2(SEP_DEPTH) : 1;
	localparam int SAW      = $clog2(STORE_DEPTH + LEAF_SPAN + 1);
	localparam int TW       = $clog2(STORE_DEPTH + DELTA_DEPTH + 1);

	localparam logic [CW-1:0]  ONE_C = CW'(1);
	localparam logic [DCW-1:0] ONE_D = DCW'(1);

	// memories
	logic [63:0] skey_mem [STORE_DEPTH];
	logic [63:0] sval_mem [STORE_DEPTH];
	logic [63:0] dkey_mem [DELTA_DEPTH];
	logic [63:0] dval_mem [DELTA_DEPTH];
	logic [63:0] sep_mem  [SEP_DEPTH];

	logic [63:0] skey_rd_q, sval_rd_q, dkey_rd_q, dval_rd_q;

	// operation registers
	logic [1:0]  op_q;
	logic [63:0] key_q, val_q, high_q;
	logic [CW-1:0]  ecnt_q;
	logic [DCW-1:0] dcnt_q;
	logic [CW-1:0]  lo_q, hi_q, q_q;
	logic [DCW-1:0] i_q, j_q;
	logic [63:0]    sk_q, sv_q;
	logic [CW-1:0]  mi_q, mn_q;
	logic [DCW-1:0] mj_q;
	logic [SAW-1:0] sa_q;
	logic [SPW-1:0] sl_q;

	// result registers
	logic [1:0]       res_status_q;
	logic             res_found_q;
	logic [63:0]      res_fval_q, ksum_q, vsum_q, fkey_q, lkey_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic [TW-1:0] total;
	logic          take_store, rg_ok, sort_less;
	logic [AW-1:0] s_raddr, s_waddr;
	logic [DAW-1:0] d_raddr, d_waddr;
	logic          s_we, d_we;
	logic [63:0]   s_wkey, s_wval, d_wkey, d_wval;

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CW:1];
	assign total      = TW'(ecnt_q) + TW'(dcnt_q);
	assign take_store = (mi_q != '0) && !($signed(skey_rd_q) < $signed(dkey_rd_q));
	assign rg_ok      = (q_q < ecnt_q) && !($signed(high_q) < $signed(skey_rd_q));
	assign sort_less  = $signed(sk_q) < $signed(dkey_rd_q);

	// status toward the controller
	always_comb begin
		stat.op          = op_q;
		stat.delta_empty = (dcnt_q == '0);
		stat.overflow    = total > TW'(STORE_DEPTH);
		stat.range_empty = (ecnt_q == '0) || ($signed(high_q) < $signed(key_q));
		stat.srch_done   = (lo_q >= hi_q);
		stat.sort_done   = (i_q >= dcnt_q);
		stat.sort_less   = sort_less;
		stat.j_one       = (j_q == ONE_D);
		stat.mrg_done    = (mj_q == '0);
		stat.sep_done    = (sa_q >= SAW'(ecnt_q));
		stat.rg_ok       = rg_ok;
		stat.out_free    = !out_valid || out_ready;
	end

	// memory address and write selection
	always_comb begin
		s_raddr = mid[AW-1:0];
		case (cmd)
			C_LK_RD:  s_raddr = lo_q[AW-1:0];
			C_RG_RD:  s_raddr = q_q[AW-1:0];
			C_MRG_RD: s_raddr = AW'(mi_q - ONE_C);
			C_SEP_RD: s_raddr = sa_q[AW-1:0];
			default:  s_raddr = mid[AW-1:0];
		endcase
		d_raddr = i_q[DAW-1:0];
		case (cmd)
			C_SORT_RDJ: d_raddr = DAW'(j_q - ONE_D);
			C_MRG_RD:   d_raddr = DAW'(mj_q - ONE_D);
			default:    d_raddr = i_q[DAW-1:0];
		endcase
		s_we    = (cmd == C_MRG_WR);
		s_waddr = AW'(mn_q - ONE_C);
		s_wkey  = take_store ? skey_rd_q : dkey_rd_q;
		s_wval  = take_store ? sval_rd_q : dval_rd_q;
		d_we    = 1'b0;
		d_waddr = j_q[DAW-1:0];
		d_wkey  = sk_q;
		d_wval  = sv_q;
		case (cmd)
			C_INS: begin
				d_we    = (dcnt_q < DCW'(DELTA_DEPTH));
				d_waddr = dcnt_q[DAW-1:0];
				d_wkey  = key_q;
				d_wval  = val_q;
			end
			C_SORT_CMP: begin
				d_we = 1'b1;
				if (sort_less) begin
					d_wkey = dkey_rd_q;
					d_wval = dval_rd_q;
				end
			end
			C_SORT_PLACE: d_we = 1'b1;
			default: d_we = 1'b0;
		endcase
	end

	// store memory
	always_ff @(posedge clk) begin
		if (s_we) begin
			skey_mem[s_waddr] <= s_wkey;
			sval_mem[s_waddr] <= s_wval;
		end
		skey_rd_q <= skey_mem[s_raddr];
		sval_rd_q <= sval_mem[s_raddr];
	end

	// delta memory
	always_ff @(posedge clk) begin
		if (d_we) begin
			dkey_mem[d_waddr] <= d_wkey;
			dval_mem[d_waddr] <= d_wval;
		end
		dkey_rd_q <= dkey_mem[d_raddr];
		dval_rd_q <= dval_mem[d_raddr];
	end

	// separator keys, one per leaf block
	always_ff @(posedge clk) begin
		if (cmd == C_SEP_WR)
			sep_mem[sl_q] <= skey_rd_q;
	end

	// counts held across operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			case (cmd)
				C_INS: begin
					if (dcnt_q < DCW'(DELTA_DEPTH))
						dcnt_q <= dcnt_q + ONE_D;
				end
				C_SEP_INIT: begin
					ecnt_q <= CW'(total);
					dcnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// working registers and result fields
	always_ff @(posedge clk) begin
		case (cmd)
			C_LOAD: begin
				op_q         <= in_op;
				key_q        <= in_key;
				val_q        <= in_value;
				high_q       <= in_high;
				res_status_q <= ST_OK;
				res_found_q  <= 1'b0;
				res_fval_q   <= '0;
				ksum_q       <= '0;
				vsum_q       <= '0;
				fkey_q       <= '0;
				lkey_q       <= '0;
				cnt_q        <= '0;
			end
			C_INS: begin
				if (dcnt_q >= DCW'(DELTA_DEPTH))
					res_status_q <= ST_DELTA_FULL;
			end
			C_BLD_OVF: res_status_q <= ST_OVERFLOW;
			C_SRCH_INIT: begin
				lo_q <= '0;
				hi_q <= ecnt_q;
			end
			C_SRCH_STEP: begin
				if ($signed(skey_rd_q) < $signed(key_q))
					lo_q <= mid + ONE_C;
				else
					hi_q <= mid;
			end
			C_LK_FIN: begin
				if ((lo_q < ecnt_q) && (skey_rd_q == key_q)) begin
					res_found_q <= 1'b1;
					res_fval_q  <= sval_rd_q;
				end else begin
					res_fval_q  <= NOT_FOUND;
				end
			end
			C_RG_INIT: q_q <= lo_q;
			C_RG_ACC: begin
				if (rg_ok) begin
					ksum_q <= ksum_q + skey_rd_q;
					vsum_q <= vsum_q + sval_rd_q;
					if (cnt_q == '0)
						fkey_q <= skey_rd_q;
					lkey_q <= skey_rd_q;
					cnt_q  <= cnt_q + CNT_W'(1);
					q_q    <= q_q + ONE_C;
				end
			end
			C_SORT_INIT: i_q <= ONE_D;
			C_SORT_KEY: begin
				sk_q <= dkey_rd_q;
				sv_q <= dval_rd_q;
				j_q  <= i_q;
			end
			C_SORT_CMP: begin
				if (sort_less)
					j_q <= j_q - ONE_D;
				else
					i_q <= i_q + ONE_D;
			end
			C_SORT_PLACE: i_q <= i_q + ONE_D;
			C_MRG_INIT: begin
				mi_q <= ecnt_q;
				mj_q <= dcnt_q;
				mn_q <= CW'(total);
			end
			C_MRG_WR: begin
				mn_q <= mn_q - ONE_C;
				if (take_store)
					mi_q <= mi_q - ONE_C;
				else
					mj_q <= mj_q - ONE_D;
			end
			C_SEP_INIT: begin
				sa_q <= '0;
				sl_q <= '0;
			end
			C_SEP_WR: begin
				sa_q <= sa_q + SAW'(LEAF_SPAN);
				sl_q <= sl_q + SPW'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd == C_FIN)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd == C_FIN) begin
			out_status <= res_status_q;
			out_found  <= res_found_q;
			out_fval   <= res_fval_q;
			out_cnt    <= cnt_q;
			out_ksum   <= ksum_q;
			out_vsum   <= vsum_q;
			out_fkey   <= fkey_q;
			out_lkey   <= lkey_q;
		end
	end

endmodule
